// File: hdl/rrsp_pkg.sv
package rrsp_pkg;

  localparam int MAX_TARGETS = 16;
  localparam int IDX_W       = $clog2(MAX_TARGETS);
  localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
  localparam int PCT_W       = 7;
  localparam int SPACE_W     = 64;
  localparam int SEED_W      = 31;
  localparam int CMD_W       = 3;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PCT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREE     = 1'd1;

  // percent compare: acc = (min+1)*total - 100*free, signed
  localparam int MULT_W   = PCT_W + 1;
  localparam int OP_W     = SPACE_W + MULT_W;
  localparam int ACC_W    = OP_W + 1;
  localparam logic [MULT_W-1:0] PCT_SCALE = MULT_W'(100);
  localparam int PCT_SWAP = MULT_W - 1;
  localparam int PCT_LAST = MULT_W + PCT_W - 1;
  localparam int MOD_LAST = SEED_W - 1;
  localparam int STEP_W   = $clog2(SEED_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_STAT     = 3'd1,
    CMD_UP       = 3'd2,
    CMD_DOWN     = 3'd3,
    CMD_SEED     = 3'd4
  } cmd_t;

  typedef enum logic {
    MODE_PCT = 1'b0,
    MODE_MOD = 1'b1
  } calc_mode_t;

  typedef struct packed {
    logic       start;
    calc_mode_t mode;
  } calc_req_t;

  typedef struct packed {
    logic             done;
    logic             low;
    logic [IDX_W-1:0] rem;
  } calc_rsp_t;

endpackage

// File: hdl/rrsp_calc.sv
// Shared add/subtract unit with its step sequencer.
// MODE_PCT: sign of (min+1)*total - 100*free, shift-and-add, one bit a step.
// MODE_MOD: restoring remainder of dividend by count, one bit a step.
module rrsp_calc import rrsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  calc_req_t           req,
  input  logic [SPACE_W-1:0]  free_space,
  input  logic [SPACE_W-1:0]  total_space,
  input  logic [PCT_W-1:0]    min_free_percent,
  input  logic [SEED_W-1:0]   dividend,
  input  logic [CNT_W-1:0]    count,
  output calc_rsp_t           rsp
);

  logic              busy;
  logic              done;
  calc_mode_t        mode;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  acc;
  logic [OP_W-1:0]   op;
  logic [MULT_W-1:0] mult;
  logic [SPACE_W-1:0] fsat;
  logic [SEED_W-1:0] div;
  logic [IDX_W-1:0]  rem;

  logic [ACC_W-1:0]  a_op;
  logic [ACC_W-1:0]  b_op;
  logic              sub;
  logic [ACC_W-1:0]  sum;
  logic              last;

  always_comb begin
    if (mode == MODE_MOD) begin
      a_op = {{(ACC_W-IDX_W-1){1'b0}}, rem, div[SEED_W-1]};
      b_op = {{(ACC_W-CNT_W){1'b0}}, count};
      sub  = 1'b1;
    end else begin
      a_op = acc;
      b_op = {1'b0, op};
      sub  = (step > STEP_W'(PCT_SWAP));
    end
    sum  = sub ? (a_op - b_op) : (a_op + b_op);
    last = (mode == MODE_MOD) ? (step == STEP_W'(MOD_LAST)) : (step == STEP_W'(PCT_LAST));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      step <= '0;
      acc  <= '0;
      op   <= {{MULT_W{1'b0}}, total_space};
      mult <= MULT_W'(min_free_percent) + MULT_W'(1);
      fsat <= (free_space > total_space) ? total_space : free_space;
      div  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (mode == MODE_MOD) begin
        div <= div << 1;
        rem <= sum[ACC_W-1] ? a_op[IDX_W-1:0] : sum[IDX_W-1:0];
      end else begin
        if (mult[0]) begin
          acc <= sum;
        end
        if (step == STEP_W'(PCT_SWAP)) begin
          op   <= {{MULT_W{1'b0}}, fsat};
          mult <= PCT_SCALE;
        end else begin
          op   <= op << 1;
          mult <= mult >> 1;
        end
      end
    end
  end

  // low when 100*free < (min+1)*total, i.e. acc strictly positive
  assign rsp.done = done;
  assign rsp.low  = ~acc[ACC_W-1] & (|acc);
  assign rsp.rem  = rem;

endmodule

// File: hdl/rr_storage_target_picker_top.sv
// Round-robin storage target picker with two priority tiers.
// Request channel: req_valid/req_stall with command, target_index, report_ok,
//   free_space, total_space, seed_present, seed_value. A transfer happens when
//   req_valid is high and req_stall low. req_stall stays high while an item is
//   being worked on; one item is handled at a time.
// Response channel: rsp_valid/rsp_stall with chosen_target, chosen_valid. Only
//   a schedule request yields a response transfer.
// Item handling: target up/down, failed stat report, zero-total report and
//   seed reply without seed finish in the accept cycle. A stat report runs 15
//   steps of the shared adder. A seed reply with seed runs 31 remainder steps.
//   A schedule scans one target per cycle, up to count targets, and then posts
//   the result from its done state once the response register is free; when
//   the stored scan start is not below the current count, a 31-step remainder
//   pass comes first.
// Response register: a new item is accepted while a result waits; a finished
//   schedule holds in its done state until the response register is free.
// Config: cfg_write/cfg_index/cfg_data; the user must write only while idle, the block does not enforce it.
// Reset: all targets online, none low on space, scan start 0, count 1,
//   threshold 0, no response pending.
module rr_storage_target_picker_top import rrsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [IDX_W-1:0]      target_index,
  input  logic                  report_ok,
  input  logic [SPACE_W-1:0]    free_space,
  input  logic [SPACE_W-1:0]    total_space,
  input  logic                  seed_present,
  input  logic [SEED_W-1:0]     seed_value,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [IDX_W-1:0]      chosen_target,
  output logic                  chosen_valid
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CALC = 6'b000010,
    ST_SEED = 6'b000100,
    ST_WRAP = 6'b001000,
    ST_SCAN = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       target_count;
  logic [PCT_W-1:0]       min_free_percent;
  logic [MAX_TARGETS-1:0] online;
  logic [MAX_TARGETS-1:0] low_space;
  logic [IDX_W-1:0]       next_start;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       ptr;
  logic [IDX_W-1:0]       k;
  logic                   have_any;
  logic [IDX_W-1:0]       any_t;
  logic [IDX_W-1:0]       res_target;
  logic                   res_valid;

  logic [CNT_W-1:0]       count;
  logic                   accept;
  logic                   idx_ok;
  logic                   slot_free;
  logic [SEED_W-1:0]      dividend;
  calc_req_t              calc_req;
  calc_rsp_t              calc_rsp;

  // scan step
  logic                   hit_free;
  logic                   hit_any;
  logic                   scan_last;

  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] v,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(v) + CNT_W'(1);
    return (nxt == cnt) ? '0 : nxt[IDX_W-1:0];
  endfunction

  always_comb begin
    if (target_count == '0) begin
      count = CNT_W'(1);
    end else if (target_count > CNT_W'(MAX_TARGETS)) begin
      count = CNT_W'(MAX_TARGETS);
    end else begin
      count = target_count;
    end
  end

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid & ~req_stall;
  assign idx_ok    = (CNT_W'(target_index) < count);
  assign slot_free = ~rsp_valid | ~rsp_stall;

  // start decisions for the shared unit
  always_comb begin
    calc_req.start = 1'b0;
    calc_req.mode  = MODE_PCT;
    dividend       = seed_value;
    if (accept) begin
      case (cmd_t'(command))
        CMD_SCHEDULE: begin
          if (CNT_W'(next_start) >= count) begin
            calc_req.start = 1'b1;
            calc_req.mode  = MODE_MOD;
            dividend       = SEED_W'(next_start);
          end
        end
        CMD_STAT: begin
          if (idx_ok && report_ok && (total_space != '0)) begin
            calc_req.start = 1'b1;
          end
        end
        CMD_SEED: begin
          if (report_ok && seed_present) begin
            calc_req.start = 1'b1;
            calc_req.mode  = MODE_MOD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  rrsp_calc u_calc (
    .clk              (clk),
    .rst              (rst),
    .req              (calc_req),
    .free_space       (free_space),
    .total_space      (total_space),
    .min_free_percent (min_free_percent),
    .dividend         (dividend),
    .count            (count),
    .rsp              (calc_rsp)
  );

  assign hit_free  = online[ptr] & ~low_space[ptr];
  assign hit_any   = online[ptr];
  assign scan_last = (CNT_W'(k) + CNT_W'(1) == count);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_count     <= CNT_W'(1);
      min_free_percent <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TARGET_COUNT: target_count     <= cfg_data[CNT_W-1:0];
        CFG_MIN_FREE:     min_free_percent <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and target state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      online     <= '1;
      low_space  <= '0;
      next_start <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd_t'(command))
              CMD_SCHEDULE: begin
                if (calc_req.start) begin
                  state <= ST_WRAP;
                end else begin
                  ptr      <= next_start;
                  k        <= '0;
                  have_any <= 1'b0;
                  state    <= ST_SCAN;
                end
              end
              CMD_STAT: begin
                if (idx_ok) begin
                  if (!report_ok) begin
                    online[target_index] <= 1'b0;
                  end else if (total_space == '0) begin
                    low_space[target_index] <= 1'b1;
                  end else begin
                    idx   <= target_index;
                    state <= ST_CALC;
                  end
                end
              end
              CMD_UP: begin
                if (idx_ok) online[target_index] <= 1'b1;
              end
              CMD_DOWN: begin
                if (idx_ok) online[target_index] <= 1'b0;
              end
              CMD_SEED: begin
                if (report_ok) begin
                  if (seed_present) begin
                    state <= ST_SEED;
                  end else begin
                    next_start <= inc_wrap('0, count);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CALC: begin
          if (calc_rsp.done) begin
            low_space[idx] <= calc_rsp.low;
            state          <= ST_IDLE;
          end
        end
        ST_SEED: begin
          if (calc_rsp.done) begin
            next_start <= inc_wrap(calc_rsp.rem, count);
            state      <= ST_IDLE;
          end
        end
        ST_WRAP: begin
          if (calc_rsp.done) begin
            ptr      <= calc_rsp.rem;
            k        <= '0;
            have_any <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit_free) begin
            res_target <= ptr;
            res_valid  <= 1'b1;
            next_start <= inc_wrap(ptr, count);
            state      <= ST_DONE;
          end else if (scan_last) begin
            // no free-space target: fall back to first online one
            if (have_any) begin
              res_target <= any_t;
              res_valid  <= 1'b1;
              next_start <= inc_wrap(any_t, count);
            end else if (hit_any) begin
              res_target <= ptr;
              res_valid  <= 1'b1;
              next_start <= inc_wrap(ptr, count);
            end else begin
              res_target <= '0;
              res_valid  <= 1'b0;
            end
            state <= ST_DONE;
          end else begin
            if (hit_any && !have_any) begin
              have_any <= 1'b1;
              any_t    <= ptr;
            end
            ptr <= inc_wrap(ptr, count);
            k   <= k + IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (slot_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      chosen_target <= res_target;
      chosen_valid  <= res_valid;
    end
  end

endmodule
